[rtl/elex_pkg.sv]
// Shared types and constants for the expression lexer.
// Holds token kinds, error codes, character codes and the result token layout.
// No dependencies.
package elex_pkg;

    // Default sizes of the internal accumulator and position counters.
    localparam int unsigned VALUE_BITS_DEF    = 31;
    localparam int unsigned POSITION_BITS_DEF = 16;

    // Fixed widths of the result fields.
    localparam int unsigned OUT_VALUE_BITS = 31;
    localparam int unsigned OUT_POS_BITS   = 16;
    localparam int unsigned LEN_BITS       = 16;

    // Depth of the result queue; it must hold at least the two tokens of one item.
    localparam int unsigned QUEUE_DEPTH = 4;

    // Token kinds.
    typedef enum logic [3:0] {
        K_INT    = 4'd0,
        K_PLUS   = 4'd1,
        K_MINUS  = 4'd2,
        K_MUL    = 4'd3,
        K_DIV    = 4'd4,
        K_LPAR   = 4'd5,
        K_RPAR   = 4'd6,
        K_ASSIGN = 4'd7,
        K_SEMI   = 4'd8,
        K_IDENT  = 4'd9,
        K_END    = 4'd10,
        K_ERROR  = 4'd11
    } t_kind;

    // Error codes carried by error tokens.
    typedef enum logic [1:0] {
        E_NONE        = 2'd0,
        E_ILLEGAL     = 2'd1,
        E_AFTER_DIGIT = 2'd2,
        E_AFTER_COLON = 2'd3
    } t_err;

    // Character codes.
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_Z   = 8'h7A;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_LPAR    = 8'h28;
    localparam logic [7:0] CH_RPAR    = 8'h29;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;

    // One result token as it is queued for output.
    typedef struct packed {
        t_kind                      kind;
        logic [OUT_VALUE_BITS-1:0]  value;
        logic                       ovf;
        logic [LEN_BITS-1:0]        len;
        logic [OUT_POS_BITS-1:0]    line;
        logic [OUT_POS_BITS-1:0]    col;
        t_err                       err;
        logic                       last;
    } t_tok;

endpackage

[rtl/expression_lexer_fsm_top.sv]
// Output: the tokens of a character are registered into the result queue when the character is taken.
// Throughput: one character per cycle while each character yields at most one token
// and the master side takes every token; a character that closes a pending token and
// emits its own yields two tokens, and the four-entry result queue then throttles the slave side.
// Reset: synchronous, active low; the lexer goes idle at line 1, column 1, queue empty.
// Top level of the expression lexer; depends on elex_pkg.
module expression_lexer_fsm_top #(
    parameter int unsigned VALUE_BITS    = elex_pkg::VALUE_BITS_DEF,
    parameter int unsigned POSITION_BITS = elex_pkg::POSITION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave side: character stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_code
    input  logic        i_s_tlast,   // end_of_input
    // Master side: token stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [30:0] int_value, [31] overflow, [47:32] token_length, [63:48] start_line,
    // [79:64] start_column, [81:80] error_code, [87:82] zero
    output logic [87:0] o_m_tdata,
    output logic [3:0]  o_m_tuser,   // [3:0] token_kind
    output logic        o_m_tlast    // last
);

    localparam int unsigned PW        = VALUE_BITS + 4;
    localparam int unsigned DEPTH     = elex_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_BITS  = $clog2(DEPTH);
    localparam int unsigned CNT_BITS  = $clog2(DEPTH + 1);
    localparam int unsigned LB        = elex_pkg::LEN_BITS;
    localparam int unsigned OPB       = elex_pkg::OUT_POS_BITS;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_INT   = 2'd1,
        ST_IDENT = 2'd2,
        ST_COLON = 2'd3
    } t_state;

    // Lexer state.
    t_state                   r_state, n_state;
    logic [VALUE_BITS-1:0]    r_acc, n_acc;
    logic                     r_ovf, n_ovf;
    logic [LB-1:0]            r_len, n_len;
    logic [POSITION_BITS-1:0] r_tok_line, n_tok_line;
    logic [POSITION_BITS-1:0] r_tok_col, n_tok_col;
    logic [POSITION_BITS-1:0] r_cur_line, n_cur_line;
    logic [POSITION_BITS-1:0] r_cur_col, n_cur_col;

    // Result queue.
    elex_pkg::t_tok           r_queue [DEPTH];
    logic [PTR_BITS-1:0]      r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0]      r_count;

    elex_pkg::t_tok           step_tok [2];
    logic [1:0]               step_cnt;
    logic                     s_accept;
    logic                     m_pop;

    assign s_accept   = i_s_tvalid && o_s_tready;
    assign m_pop      = o_m_tvalid && i_m_tready;
    assign o_s_tready = (r_count <= CNT_BITS'(DEPTH - 2));
    assign o_m_tvalid = (r_count != '0);

    function automatic elex_pkg::t_tok make_tok(
        input elex_pkg::t_kind          kind,
        input logic [VALUE_BITS-1:0]    value,
        input logic                     ovf,
        input logic [LB-1:0]            len,
        input logic [POSITION_BITS-1:0] line,
        input logic [POSITION_BITS-1:0] col,
        input elex_pkg::t_err           err
    );
        elex_pkg::t_tok t;
        t.kind  = kind;
        t.value = elex_pkg::OUT_VALUE_BITS'(value);
        t.ovf   = ovf;
        t.len   = len;
        t.line  = OPB'(line);
        t.col   = OPB'(col);
        t.err   = err;
        t.last  = 1'b0;
        return t;
    endfunction

    function automatic logic [POSITION_BITS-1:0] pos_inc(input logic [POSITION_BITS-1:0] x);
        return (x == '1) ? x : x + POSITION_BITS'(1);
    endfunction

    function automatic logic [LB-1:0] len_inc(input logic [LB-1:0] x);
        return (x == '1) ? x : x + LB'(1);
    endfunction

    // One character step: state update and up to two tokens.
    always_comb begin
        logic [7:0]         c;
        logic               is_digit;
        logic               is_letter;
        logic               again;
        logic [3:0]         dig;
        logic [PW-1:0]      prod;
        elex_pkg::t_tok     pend;
        elex_pkg::t_tok     tk;
        logic               have_tk;

        c         = i_s_tdata;
        is_digit  = (c >= elex_pkg::CH_ZERO) && (c <= elex_pkg::CH_NINE);
        is_letter = ((c >= elex_pkg::CH_LOW_A) && (c <= elex_pkg::CH_LOW_Z)) ||
                    ((c >= elex_pkg::CH_UP_A) && (c <= elex_pkg::CH_UP_Z));
        dig       = 4'(c - elex_pkg::CH_ZERO);
        prod      = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + PW'(dig);
        again     = 1'b0;
        tk        = '0;
        have_tk   = 1'b0;

        n_state    = r_state;
        n_acc      = r_acc;
        n_ovf      = r_ovf;
        n_len      = r_len;
        n_tok_line = r_tok_line;
        n_tok_col  = r_tok_col;
        n_cur_line = r_cur_line;
        n_cur_col  = r_cur_col;
        step_tok[0] = '0;
        step_tok[1] = '0;
        step_cnt    = 2'd0;

        // Token that a closing character emits for the pending state.
        case (r_state)
            ST_INT:   pend = make_tok(elex_pkg::K_INT, r_acc, r_ovf, r_len,
                                      r_tok_line, r_tok_col, elex_pkg::E_NONE);
            ST_IDENT: pend = make_tok(elex_pkg::K_IDENT, '0, 1'b0, r_len,
                                      r_tok_line, r_tok_col, elex_pkg::E_NONE);
            ST_COLON: pend = make_tok(elex_pkg::K_ERROR, '0, 1'b0, LB'(1),
                                      r_tok_line, r_tok_col, elex_pkg::E_AFTER_COLON);
            default:  pend = '0;
        endcase

        if (i_s_tlast) begin
            // End of input: close the pending token, then the end token, then reset.
            if (r_state != ST_IDLE) begin
                step_tok[0] = pend;
                step_cnt    = 2'd1;
            end
            step_tok[step_cnt[0]] = make_tok(elex_pkg::K_END, '0, 1'b0, '0,
                                             r_cur_line, r_cur_col, elex_pkg::E_NONE);
            step_cnt   = step_cnt + 2'd1;
            n_state    = ST_IDLE;
            n_acc      = '0;
            n_ovf      = 1'b0;
            n_len      = '0;
            n_tok_line = POSITION_BITS'(1);
            n_tok_col  = POSITION_BITS'(1);
            n_cur_line = POSITION_BITS'(1);
            n_cur_col  = POSITION_BITS'(1);
        end else begin
            // Pending token: extend it, or close it and treat the character afresh.
            case (r_state)
                ST_INT: begin
                    if (is_digit) begin
                        if (r_ovf || (prod[PW-1:VALUE_BITS] != '0)) begin
                            n_acc = '1;
                            n_ovf = 1'b1;
                        end else begin
                            n_acc = prod[VALUE_BITS-1:0];
                        end
                        n_len = len_inc(r_len);
                    end else if (is_letter) begin
                        tk = make_tok(elex_pkg::K_ERROR, '0, 1'b0, len_inc(r_len),
                                      r_tok_line, r_tok_col, elex_pkg::E_AFTER_DIGIT);
                        have_tk = 1'b1;
                        n_state = ST_IDLE;
                        n_acc   = '0;
                        n_ovf   = 1'b0;
                        n_len   = '0;
                    end else begin
                        tk      = pend;
                        have_tk = 1'b1;
                        again   = 1'b1;
                    end
                end
                ST_IDENT: begin
                    if (is_digit || is_letter) begin
                        n_len = len_inc(r_len);
                    end else begin
                        tk      = pend;
                        have_tk = 1'b1;
                        again   = 1'b1;
                    end
                end
                ST_COLON: begin
                    if (c == elex_pkg::CH_EQUALS) begin
                        tk = make_tok(elex_pkg::K_ASSIGN, '0, 1'b0, LB'(2),
                                      r_tok_line, r_tok_col, elex_pkg::E_NONE);
                        have_tk = 1'b1;
                        n_state = ST_IDLE;
                        n_acc   = '0;
                        n_ovf   = 1'b0;
                        n_len   = '0;
                    end else begin
                        tk      = pend;
                        have_tk = 1'b1;
                        again   = 1'b1;
                    end
                end
                default: begin
                    again = 1'b1;
                end
            endcase

            if (have_tk) begin
                step_tok[0] = tk;
                step_cnt    = 2'd1;
            end

            // Character seen from idle.
            if (again) begin
                n_state = ST_IDLE;
                n_acc   = '0;
                n_ovf   = 1'b0;
                n_len   = '0;
                if ((c == elex_pkg::CH_SPACE) || (c == elex_pkg::CH_TAB) ||
                    (c == elex_pkg::CH_NEWLINE)) begin
                    have_tk = 1'b0;
                end else if (is_digit || is_letter || (c == elex_pkg::CH_COLON)) begin
                    n_state    = is_digit ? ST_INT : (is_letter ? ST_IDENT : ST_COLON);
                    n_acc      = is_digit ? VALUE_BITS'(dig) : '0;
                    n_len      = LB'(1);
                    n_tok_line = r_cur_line;
                    n_tok_col  = r_cur_col;
                end else begin
                    case (c)
                        elex_pkg::CH_PLUS:  tk.kind = elex_pkg::K_PLUS;
                        elex_pkg::CH_MINUS: tk.kind = elex_pkg::K_MINUS;
                        elex_pkg::CH_STAR:  tk.kind = elex_pkg::K_MUL;
                        elex_pkg::CH_SLASH: tk.kind = elex_pkg::K_DIV;
                        elex_pkg::CH_LPAR:  tk.kind = elex_pkg::K_LPAR;
                        elex_pkg::CH_RPAR:  tk.kind = elex_pkg::K_RPAR;
                        elex_pkg::CH_SEMI:  tk.kind = elex_pkg::K_SEMI;
                        default:            tk.kind = elex_pkg::K_ERROR;
                    endcase
                    step_tok[step_cnt[0]] = make_tok(tk.kind, '0, 1'b0, LB'(1), r_cur_line,
                        r_cur_col, (tk.kind == elex_pkg::K_ERROR) ? elex_pkg::E_ILLEGAL
                                                                  : elex_pkg::E_NONE);
                    step_cnt = step_cnt + 2'd1;
                end
            end

            // Running position.
            if (c == elex_pkg::CH_NEWLINE) begin
                n_cur_line = pos_inc(r_cur_line);
                n_cur_col  = POSITION_BITS'(1);
            end else begin
                n_cur_col  = pos_inc(r_cur_col);
            end
        end

        // Mark the final token of this step.
        if (step_cnt == 2'd2) begin
            step_tok[1].last = 1'b1;
        end else if (step_cnt == 2'd1) begin
            step_tok[0].last = 1'b1;
        end
    end

    // Lexer state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_acc      <= '0;
            r_ovf      <= 1'b0;
            r_len      <= '0;
            r_tok_line <= POSITION_BITS'(1);
            r_tok_col  <= POSITION_BITS'(1);
            r_cur_line <= POSITION_BITS'(1);
            r_cur_col  <= POSITION_BITS'(1);
        end else if (s_accept) begin
            r_state    <= n_state;
            r_acc      <= n_acc;
            r_ovf      <= n_ovf;
            r_len      <= n_len;
            r_tok_line <= n_tok_line;
            r_tok_col  <= n_tok_col;
            r_cur_line <= n_cur_line;
            r_cur_col  <= n_cur_col;
        end
    end

    // Result queue storage; entries need no reset.
    always_ff @(posedge i_clk) begin
        if (s_accept && (step_cnt != 2'd0)) begin
            r_queue[r_wr_ptr] <= step_tok[0];
        end
        if (s_accept && (step_cnt == 2'd2)) begin
            r_queue[r_wr_ptr + PTR_BITS'(1)] <= step_tok[1];
        end
    end

    // Result queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (s_accept) begin
                r_wr_ptr <= r_wr_ptr + PTR_BITS'(step_cnt);
            end
            if (m_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_BITS'(1);
            end
            r_count <= r_count + (s_accept ? CNT_BITS'(step_cnt) : '0)
                               - CNT_BITS'(m_pop);
        end
    end

    // Output transfer fields.
    assign o_m_tuser = r_queue[r_rd_ptr].kind;
    assign o_m_tlast = r_queue[r_rd_ptr].last;
    assign o_m_tdata = {6'b0,
                        r_queue[r_rd_ptr].err,
                        r_queue[r_rd_ptr].col,
                        r_queue[r_rd_ptr].line,
                        r_queue[r_rd_ptr].len,
                        r_queue[r_rd_ptr].ovf,
                        r_queue[r_rd_ptr].value};

    // The queue never holds more than its depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(DEPTH))
        else $error("result queue overfilled");

    // A character is only taken when room for two tokens remains.
    a_room_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |-> (r_count <= CNT_BITS'(DEPTH - 2)))
        else $error("character taken without room for its tokens");

    // End of input returns the lexer to its reset position.
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_tlast) |=> (r_state == ST_IDLE) &&
            (r_cur_line == POSITION_BITS'(1)) && (r_cur_col == POSITION_BITS'(1)))
        else $error("lexer not reset after end of input");

    // An end token always closes its step.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == elex_pkg::K_END)) |-> o_m_tlast)
        else $error("end token without last mark");

    // Only error tokens carry an error code.
    a_err_only_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != elex_pkg::K_ERROR)) |-> (o_m_tdata[81:80] == 2'd0))
        else $error("error code on a non-error token");

endmodule

[sim/expression_lexer_fsm_top_tb.sv]
// Self-checking testbench for the expression lexer top level.
// A scoreboard class predicts the tokens of every accepted character and checks the token stream.
// Depends on elex_pkg and expression_lexer_fsm_top.
module expression_lexer_fsm_top_tb;
    import elex_pkg::*;

    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned HOLD_CYCLES = 300;

    // Token predictor and store of expected tokens.
    class token_scoreboard;
        typedef enum logic [1:0] {LX_IDLE, LX_INT, LX_IDENT, LX_COLON} t_lex_state;

        t_lex_state  state;
        logic [30:0] acc;
        logic        ovf_seen;
        logic [15:0] len_cnt;
        logic [15:0] tok_line;
        logic [15:0] tok_col;
        logic [15:0] cur_line;
        logic [15:0] cur_col;
        t_tok        expected_tokens[$];
        int unsigned fails;

        function new();
            fails = 0;
            reset_all();
        endfunction

        function logic [15:0] sat_inc(logic [15:0] x);
            return (x == 16'hFFFF) ? x : x + 16'd1;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
        endfunction

        function void add_token(t_kind kind, logic [30:0] val, logic ovf, logic [15:0] len,
                                logic [15:0] line, logic [15:0] col, t_err err);
            t_tok t;
            t.kind  = kind;
            t.value = val;
            t.ovf   = ovf;
            t.len   = len;
            t.line  = line;
            t.col   = col;
            t.err   = err;
            t.last  = 1'b0;
            expected_tokens.push_back(t);
        endfunction

        function void clear_token();
            state    = LX_IDLE;
            acc      = '0;
            ovf_seen = 1'b0;
            len_cnt  = '0;
        endfunction

        function void reset_all();
            clear_token();
            tok_line = 16'd1;
            tok_col  = 16'd1;
            cur_line = 16'd1;
            cur_col  = 16'd1;
        endfunction

        function void open_token(t_lex_state s, logic [30:0] v);
            state    = s;
            acc      = v;
            ovf_seen = 1'b0;
            len_cnt  = 16'd1;
            tok_line = cur_line;
            tok_col  = cur_col;
        endfunction

        // Emits whatever token is pending when a character cannot extend it.
        function void close_token();
            case (state)
                LX_INT:   add_token(K_INT, acc, ovf_seen, len_cnt, tok_line, tok_col, E_NONE);
                LX_IDENT: add_token(K_IDENT, '0, 1'b0, len_cnt, tok_line, tok_col, E_NONE);
                LX_COLON: add_token(K_ERROR, '0, 1'b0, 16'd1, tok_line, tok_col, E_AFTER_COLON);
                default: ;
            endcase
            clear_token();
        endfunction

        // Handles a character with no token pending.
        function void lex_idle(logic [7:0] c);
            t_kind kind;
            t_err  err;
            if (c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE)
                return;
            if (is_digit(c)) begin
                open_token(LX_INT, 31'(c - CH_ZERO));
                return;
            end
            if (is_letter(c)) begin
                open_token(LX_IDENT, '0);
                return;
            end
            if (c == CH_COLON) begin
                open_token(LX_COLON, '0);
                return;
            end
            err = E_NONE;
            case (c)
                CH_PLUS:  kind = K_PLUS;
                CH_MINUS: kind = K_MINUS;
                CH_STAR:  kind = K_MUL;
                CH_SLASH: kind = K_DIV;
                CH_LPAR:  kind = K_LPAR;
                CH_RPAR:  kind = K_RPAR;
                CH_SEMI:  kind = K_SEMI;
                default: begin
                    kind = K_ERROR;
                    err  = E_ILLEGAL;
                end
            endcase
            add_token(kind, '0, 1'b0, 16'd1, cur_line, cur_col, err);
        endfunction

        // Notes one accepted character transfer and queues the tokens it causes.
        function void note_char(logic [7:0] c, logic eoi);
            int unsigned n0;
            int unsigned d;
            bit          again;
            t_tok        t;
            n0 = expected_tokens.size();
            if (eoi) begin
                close_token();
                add_token(K_END, '0, 1'b0, 16'd0, cur_line, cur_col, E_NONE);
                reset_all();
            end else begin
                again = 1'b1;
                case (state)
                    LX_INT: begin
                        if (is_digit(c)) begin
                            d = c - CH_ZERO;
                            if (ovf_seen || acc > (32'h7FFF_FFFF - d) / 10) begin
                                acc      = '1;
                                ovf_seen = 1'b1;
                            end else begin
                                acc = 31'(acc * 10 + d);
                            end
                            len_cnt = sat_inc(len_cnt);
                            again   = 1'b0;
                        end else if (is_letter(c)) begin
                            add_token(K_ERROR, '0, 1'b0, sat_inc(len_cnt), tok_line, tok_col,
                                      E_AFTER_DIGIT);
                            clear_token();
                            again = 1'b0;
                        end else begin
                            close_token();
                        end
                    end
                    LX_IDENT: begin
                        if (is_digit(c) || is_letter(c)) begin
                            len_cnt = sat_inc(len_cnt);
                            again   = 1'b0;
                        end else begin
                            close_token();
                        end
                    end
                    LX_COLON: begin
                        if (c == CH_EQUALS) begin
                            add_token(K_ASSIGN, '0, 1'b0, 16'd2, tok_line, tok_col, E_NONE);
                            clear_token();
                            again = 1'b0;
                        end else begin
                            close_token();
                        end
                    end
                    default: ;
                endcase
                if (again)
                    lex_idle(c);
                if (c == CH_NEWLINE) begin
                    cur_line = sat_inc(cur_line);
                    cur_col  = 16'd1;
                end else begin
                    cur_col = sat_inc(cur_col);
                end
            end
            // The final token of the character carries the last flag.
            if (expected_tokens.size() > n0) begin
                t      = expected_tokens.pop_back();
                t.last = 1'b1;
                expected_tokens.push_back(t);
            end
        endfunction

        function void compare(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                fails++;
            end
        endfunction

        // Checks one token transfer against the oldest expectation.
        function void check_token(logic [87:0] data, logic [3:0] kind, logic last);
            t_tok want;
            if (expected_tokens.size() == 0) begin
                $error("token of kind %0d arrived with nothing expected", kind);
                fails++;
                return;
            end
            want = expected_tokens.pop_front();
            compare("token_kind", want.kind, kind);
            compare("int_value", want.value, data[30:0]);
            compare("overflow", want.ovf, data[31]);
            compare("token_length", want.len, data[47:32]);
            compare("start_line", want.line, data[63:48]);
            compare("start_column", want.col, data[79:64]);
            compare("error_code", want.err, data[81:80]);
            compare("padding", 0, data[87:82]);
            compare("last", want.last, last);
        endfunction

        function void check_drained();
            if (expected_tokens.size() != 0) begin
                $error("%0d expected tokens never arrived", expected_tokens.size());
                fails++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [87:0] o_m_tdata;
    logic [3:0]  o_m_tuser;
    logic        o_m_tlast;

    token_scoreboard sb = new();
    int unsigned     phase_no;
    int unsigned     sender_idle_pct;
    int unsigned     receiver_stall_pct;
    int unsigned     items_sent;
    int unsigned     quiet_cycles;

    expression_lexer_fsm_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #6 i_clk = ~i_clk;

    // Receiver: random stalls, plus one long hold-off right after reset, during the directed cases.
    initial begin : receiver
        int unsigned hold_left;
        bit          held;
        hold_left  = 0;
        held       = 1'b0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (phase_no == 0 && !held && i_rst_n) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Token monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_token(o_m_tdata, o_m_tuser, o_m_tlast);
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("[expression_lexer_fsm_top] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one character after a random gap and waits for its transfer.
    task automatic push_char(logic [7:0] c, logic eoi);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        @(negedge i_clk);
        repeat (gap) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tlast  <= eoi;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        sb.note_char(c, eoi);
        items_sent++;
    endtask

    task automatic push_text(string s);
        for (int k = 0; k < s.len(); k++)
            push_char(s[k], 1'b0);
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'(CH_ZERO + $urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_letter();
        return 8'(($urandom_range(1) ? CH_LOW_A : CH_UP_A) + $urandom_range(25));
    endfunction

    // Sends one random lexeme, mostly well formed, sometimes broken or noise.
    task automatic emit_random_lexeme();
        string       ops;
        string       seps;
        logic [7:0]  c;
        int unsigned n;
        ops  = "+-*/();";
        seps = " \t\n";
        case ($urandom_range(15))
            0, 1, 2, 3: begin
                n = ($urandom_range(7) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 4);
                repeat (n) push_char(rand_digit(), 1'b0);
            end
            4, 5, 6: begin
                push_char(rand_letter(), 1'b0);
                repeat ($urandom_range(8))
                    push_char($urandom_range(2) == 0 ? rand_digit() : rand_letter(), 1'b0);
            end
            7, 8, 9, 10: push_char(ops[$urandom_range(6)], 1'b0);
            11: push_text(":=");
            12: push_text($urandom_range(1) ? "2147483647" : "2147483648");
            13: begin
                case ($urandom_range(2))
                    0: begin
                        repeat ($urandom_range(1, 3)) push_char(rand_digit(), 1'b0);
                        push_char(rand_letter(), 1'b0);
                    end
                    1: begin
                        c = 8'($urandom_range(255));
                        if (c == CH_EQUALS)
                            c = CH_PLUS;
                        push_char(CH_COLON, 1'b0);
                        push_char(c, 1'b0);
                    end
                    default: push_char(CH_EQUALS, 1'b0);
                endcase
            end
            14: push_char(8'($urandom_range(255)), 1'b0);
            default: repeat ($urandom_range(1, 3)) push_char(seps[$urandom_range(2)], 1'b0);
        endcase
        // Leaving out the separator lets a closing character emit its own token too.
        if ($urandom_range(1))
            push_char(seps[$urandom_range(2)], 1'b0);
    endtask

    task automatic run_random_phase(int unsigned items);
        int unsigned start;
        start = items_sent;
        while (items_sent - start < items) begin
            repeat ($urandom_range(2, 10)) emit_random_lexeme();
            push_char(8'($urandom_range(255)), 1'b1);
        end
    endtask

    // Main sequence: reset, directed cases, then random phases.
    initial begin : stimulus
        int unsigned sender_pcts[4];
        int unsigned receiver_pcts[4];
        sender_pcts        = '{0, 84, 0, 21};
        receiver_pcts      = '{0, 0, 84, 21};
        phase_no           = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        items_sent         = 0;
        quiet_cycles       = 0;
        i_rst_n            = 1'b0;
        i_s_tvalid         = 1'b0;
        i_s_tdata          = '0;
        i_s_tlast          = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Every operator, assignment, illegal bytes, letter after digit, bad colon follow-up.
        push_text("0+-*/();:=x9 =\t1a:+7;\n");
        push_char(8'h00, 1'b0);
        push_char(8'hFF, 1'b0);
        push_text("@[`{AZaz:");
        push_char(8'hA5, 1'b1);
        // Integer saturation, closed by a blank and by the end mark.
        push_text("2147483647 2147483648 99999999999 4");
        push_char(8'h5A, 1'b1);

        for (int p = 0; p < 4; p++) begin
            phase_no           = p;
            sender_idle_pct    = sender_pcts[p];
            receiver_stall_pct = receiver_pcts[p];
            run_random_phase(130);
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (sb.expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        sb.check_drained();
        if (sb.fails == 0)
            $display("[expression_lexer_fsm_top] OK");
        else
            $display("[expression_lexer_fsm_top] ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/elex_pkg.sv
rtl/expression_lexer_fsm_top.sv
sim/expression_lexer_fsm_top_tb.sv
